// ===== rtl/bbcf_pkg.sv =====
package bbcf_pkg;

    localparam int CACHE_SLOTS  = 16;
    localparam int ADDRESS_BITS = 24;
    localparam int IDX_W        = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;

    localparam int CMD_W        = 2;
    localparam int SLOT_W       = 4;
    localparam int BADDR_W      = 24;
    localparam int IN_DATA_W    = ((BADDR_W + SLOT_W + 1 + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((SLOT_W + BADDR_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCESS = 2'd0,
        CMD_MARK   = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic                 fill;
        logic                 writeback;
        logic                 hit;
    } res_flags_t;

endpackage

// ===== rtl/bbcf_ram.sv =====
module bbcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [$clog2(DEPTH)-1:0]       waddr,
    input  logic [WIDTH-1:0]               wdata,
    input  logic [$clog2(DEPTH)-1:0]       raddr,
    output logic [WIDTH-1:0]               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/block_buffer_cache_fifo_top.sv =====
// Fully associative block buffer cache controller with round-robin replacement.
// Input channel s_axis: one command item. tuser carries the command (access,
// mark, flush), tdata the block address, slot index and dirty value.
// Result channel m_axis: slot, writeback address in tdata; hit, writeback and
// fill flags in tuser; tlast marks the final result of a command.
// An access scans the tag memory one slot per cycle with a single comparator.
// A hit goes to the HIT state, which loads one result naming the matching slot; a
// miss goes through VICTIM, where a dirty victim loads a writeback result, to
// FILL, which loads the fill result. s_axis_tready is high again in the cycle
// after the last result is loaded.
// A mark only sets or clears one dirty bit and gives no result. A flush walks
// the dirty marks one slot per cycle; a dirty slot waits for a free output.
// One command is worked on at a time; s_axis_tready is high only between
// commands. Results go out through one output register; when m_axis_tready is
// low the sequencer waits with the next result and nothing is dropped.
// After reset (aresetn low at a clock edge) slot i holds block i, all slots are
// clean and the victim pointer is slot zero; per-slot valid bits stand in for
// the tag memory contents until a slot is first filled, so no clearing pass.
module block_buffer_cache_fifo_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // block_num, slot_index, dirty_value, zero pad
    input  logic [bbcf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // command
    input  logic [bbcf_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // slot, writeback_address, zero pad
    output logic [bbcf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // hit, writeback, fill
    output logic [bbcf_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int NSLOT = bbcf_pkg::CACHE_SLOTS;
    localparam int IW    = bbcf_pkg::IDX_W;
    localparam int AW    = bbcf_pkg::ADDRESS_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(NSLOT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_HIT,
        S_VICTIM,
        S_FILL,
        S_FLUSH
    } state_t;

    state_t                         state_reg, state_next;
    logic [IW-1:0]                  idx_reg, idx_next;
    logic [IW-1:0]                  victim_reg, victim_next;
    logic [IW-1:0]                  rd_idx_reg;
    logic [AW-1:0]                  addr_reg, addr_next;
    logic [NSLOT-1:0]               dirty_reg, dirty_next;
    logic [NSLOT-1:0]               valid_reg, valid_next;

    logic                           m_valid_reg, m_valid_next;
    logic [bbcf_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    bbcf_pkg::res_flags_t           m_flags_reg, m_flags_next;
    logic                           m_last_reg, m_last_next;

    logic                           ram_we;
    logic [IW-1:0]                  ram_raddr;
    logic [AW-1:0]                  ram_rdata;
    logic [AW-1:0]                  stored_val;
    logic                           out_free;
    logic                           accept;
    logic                           rest_clean;
    bbcf_pkg::cmd_t                 cmd;
    logic [bbcf_pkg::BADDR_W-1:0]   in_baddr;
    logic [bbcf_pkg::SLOT_W-1:0]    in_slot;
    logic                           in_dval;

    assign cmd      = bbcf_pkg::cmd_t'(s_axis_tuser);
    assign in_baddr = s_axis_tdata[bbcf_pkg::BADDR_W-1:0];
    assign in_slot  = s_axis_tdata[bbcf_pkg::BADDR_W +: bbcf_pkg::SLOT_W];
    assign in_dval  = s_axis_tdata[bbcf_pkg::BADDR_W + bbcf_pkg::SLOT_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // untouched slots still hold their reset block
    assign stored_val = valid_reg[rd_idx_reg] ? ram_rdata : AW'(rd_idx_reg);
    assign rest_clean = ((dirty_reg >> idx_reg) == '0);
    assign ram_raddr  = (state_next == S_VICTIM) ? victim_reg : idx_next;

    bbcf_ram #(
        .WIDTH (AW),
        .DEPTH (NSLOT)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (victim_reg),
        .wdata (addr_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        victim_next  = victim_reg;
        addr_next    = addr_reg;
        dirty_next   = dirty_reg;
        valid_next   = valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_flags_next = m_flags_reg;
        m_last_next  = m_last_reg;
        ram_we       = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd)
                        bbcf_pkg::CMD_ACCESS: begin
                            addr_next  = AW'(in_baddr);
                            idx_next   = '0;
                            state_next = S_SEARCH;
                        end
                        bbcf_pkg::CMD_MARK: begin
                            if (32'(in_slot) < NSLOT) begin
                                dirty_next[IW'(in_slot)] = in_dval;
                            end
                        end
                        bbcf_pkg::CMD_FLUSH: begin
                            idx_next   = '0;
                            state_next = S_FLUSH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (stored_val == addr_reg) begin
                    state_next = S_HIT;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = S_VICTIM;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_HIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = bbcf_pkg::OUT_DATA_W'(bbcf_pkg::SLOT_W'(idx_reg));
                    m_flags_next = '{fill: 1'b0, writeback: 1'b0, hit: 1'b1};
                    m_last_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_VICTIM: begin
                if (!dirty_reg[victim_reg]) begin
                    state_next = S_FILL;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = bbcf_pkg::OUT_DATA_W'({
                        bbcf_pkg::BADDR_W'(stored_val),
                        bbcf_pkg::SLOT_W'(victim_reg)});
                    m_flags_next = '{fill: 1'b0, writeback: 1'b1, hit: 1'b0};
                    m_last_next  = 1'b0;
                    state_next   = S_FILL;
                end
            end
            S_FILL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = bbcf_pkg::OUT_DATA_W'(bbcf_pkg::SLOT_W'(victim_reg));
                    m_flags_next = '{fill: 1'b1, writeback: 1'b0, hit: 1'b0};
                    m_last_next  = 1'b1;
                    ram_we       = 1'b1;
                    valid_next[victim_reg] = 1'b1;
                    dirty_next[victim_reg] = 1'b0;
                    victim_next  = (victim_reg == LAST_IDX) ? '0 : victim_reg + 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (rest_clean) begin
                    state_next = S_IDLE;
                end else if (!dirty_reg[idx_reg]) begin
                    idx_next = idx_reg + 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = bbcf_pkg::OUT_DATA_W'({
                        bbcf_pkg::BADDR_W'(stored_val),
                        bbcf_pkg::SLOT_W'(idx_reg)});
                    m_flags_next = '{fill: 1'b0, writeback: 1'b1, hit: 1'b0};
                    m_last_next  = ((dirty_reg >> idx_reg) == NSLOT'(1));
                    dirty_next[idx_reg] = 1'b0;
                    if (idx_reg == LAST_IDX) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            victim_reg  <= '0;
            dirty_reg   <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            victim_reg  <= victim_next;
            dirty_reg   <= dirty_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
        end
        rd_idx_reg  <= ram_raddr;
        addr_reg    <= addr_next;
        m_data_reg  <= m_data_next;
        m_flags_reg <= m_flags_next;
        m_last_reg  <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_flags_reg;
    assign m_axis_tlast  = m_last_reg;

    a_hit_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_flags_reg.hit |->
            !m_flags_reg.writeback && !m_flags_reg.fill && m_axis_tlast)
        else $error("hit result carries writeback or fill");

    a_fill_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_flags_reg.fill |-> m_axis_tlast && !m_flags_reg.writeback)
        else $error("fill result is not the final item");

    a_victim_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$stable(victim_reg) |-> $past(state_reg == S_FILL))
        else $error("victim pointer moved outside a fill");

    a_mark_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (cmd == bbcf_pkg::CMD_MARK) |=> !$rose(m_valid_reg) && s_axis_tready)
        else $error("mark item produced a result or stalled");

endmodule

// ===== test/block_buffer_cache_fifo_top_tb.sv =====
module block_buffer_cache_fifo_top_tb;

    localparam logic [bbcf_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;
    localparam int NUM_PHASES = 4;
    localparam int RANDOM_PER_PHASE = 65;
    localparam int POOL_SIZE = 24;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [bbcf_pkg::CMD_W-1:0]   cmd;
        logic [bbcf_pkg::BADDR_W-1:0] block_addr;
        logic [bbcf_pkg::SLOT_W-1:0]  slot_idx;
        logic                         dirty_val;
        logic [1:0]                   phase;
        logic                         drain;
    } cache_cmd_t;

    typedef struct packed {
        logic [bbcf_pkg::SLOT_W-1:0]  slot;
        logic                         hit;
        logic                         writeback;
        logic [bbcf_pkg::BADDR_W-1:0] wb_addr;
        logic                         fill;
        logic                         last;
    } cache_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [bbcf_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [bbcf_pkg::CMD_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [bbcf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [bbcf_pkg::OUT_USER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    // sender idle and receiver stall percentages per phase
    int send_idle_pct [NUM_PHASES] = '{0, 74, 0, 6};
    int recv_stall_pct [NUM_PHASES] = '{0, 0, 74, 6};
    logic [1:0] recv_phase = '0;

    cache_cmd_t pending_cmds[$];
    cache_cmd_t cmd_in_flight;
    cache_result_t expected_results[$];

    logic [bbcf_pkg::BADDR_W-1:0] slot_block [bbcf_pkg::CACHE_SLOTS];
    logic slot_dirty [bbcf_pkg::CACHE_SLOTS];
    logic [bbcf_pkg::SLOT_W-1:0] victim_slot;

    logic [bbcf_pkg::BADDR_W-1:0] addr_pool [POOL_SIZE];
    int mismatch_count = 0;
    int cycle_count = 0;

    block_buffer_cache_fifo_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic cache_result_t make_result(logic [bbcf_pkg::SLOT_W-1:0] slot,
                                                  logic hit, logic wb,
                                                  logic [bbcf_pkg::BADDR_W-1:0] wb_addr,
                                                  logic fill, logic last);
        cache_result_t r;
        r.slot = slot;
        r.hit = hit;
        r.writeback = wb;
        r.wb_addr = wb_addr;
        r.fill = fill;
        r.last = last;
        return r;
    endfunction

    function automatic void predict_cache(cache_cmd_t c);
        int hit_slot;
        int first_new;
        hit_slot = -1;
        first_new = expected_results.size();
        case (c.cmd)
            bbcf_pkg::CMD_ACCESS: begin
                for (int i = 0; i < bbcf_pkg::CACHE_SLOTS; i++)
                    if (hit_slot < 0 && slot_block[i] == c.block_addr)
                        hit_slot = i;
                if (hit_slot >= 0) begin
                    expected_results.push_back(make_result(bbcf_pkg::SLOT_W'(hit_slot),
                                                           1'b1, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    if (slot_dirty[victim_slot])
                        expected_results.push_back(make_result(victim_slot, 1'b0, 1'b1,
                            slot_block[victim_slot], 1'b0, 1'b0));
                    slot_block[victim_slot] = c.block_addr;
                    slot_dirty[victim_slot] = 1'b0;
                    expected_results.push_back(make_result(victim_slot, 1'b0, 1'b0, '0,
                                                           1'b1, 1'b1));
                    victim_slot = victim_slot + 1'b1;
                end
            end
            bbcf_pkg::CMD_MARK: begin
                slot_dirty[c.slot_idx] = c.dirty_val;
            end
            bbcf_pkg::CMD_FLUSH: begin
                for (int i = 0; i < bbcf_pkg::CACHE_SLOTS; i++)
                    if (slot_dirty[i]) begin
                        expected_results.push_back(make_result(bbcf_pkg::SLOT_W'(i), 1'b0,
                                                               1'b1, slot_block[i], 1'b0,
                                                               1'b0));
                        slot_dirty[i] = 1'b0;
                    end
                if (expected_results.size() > first_new)
                    expected_results[expected_results.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_cache(cmd_in_flight);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() > 0
                    && (!pending_cmds[0].drain || expected_results.size() == 0)
                    && $urandom_range(99) >= send_idle_pct[pending_cmds[0].phase]) begin
                    cmd_in_flight = pending_cmds.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {{(bbcf_pkg::IN_DATA_W - bbcf_pkg::BADDR_W
                                       - bbcf_pkg::SLOT_W - 1){1'b0}},
                                     cmd_in_flight.dirty_val, cmd_in_flight.slot_idx,
                                     cmd_in_flight.block_addr};
                    s_axis_tuser <= cmd_in_flight.cmd;
                    recv_phase <= cmd_in_flight.phase;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cache_result_t got;
        cache_result_t want;
        bbcf_pkg::res_flags_t got_flags;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_flags = bbcf_pkg::res_flags_t'(m_axis_tuser);
                got = make_result(m_axis_tdata[bbcf_pkg::SLOT_W-1:0],
                                  got_flags.hit,
                                  got_flags.writeback,
                                  m_axis_tdata[bbcf_pkg::SLOT_W +: bbcf_pkg::BADDR_W],
                                  got_flags.fill,
                                  m_axis_tlast);
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"unexpected result: slot %0d hit %0b wb %0b addr %h",
                                  " fill %0b last %0b"},
                                 got.slot, got.hit, got.writeback, got.wb_addr, got.fill,
                                 got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got.slot !== want.slot || got.hit !== want.hit
                        || got.writeback !== want.writeback || got.wb_addr !== want.wb_addr
                        || got.fill !== want.fill || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display({"mismatch: exp slot %0d hit %0b wb %0b addr %h",
                                      " fill %0b last %0b, got slot %0d hit %0b wb %0b",
                                      " addr %h fill %0b last %0b"},
                                     want.slot, want.hit, want.writeback, want.wb_addr,
                                     want.fill, want.last, got.slot, got.hit, got.writeback,
                                     got.wb_addr, got.fill, got.last);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct[recv_phase]);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** block_buffer_cache_fifo_top: FAILED **");
            $finish;
        end
    end

    task automatic add_cmd(logic [bbcf_pkg::CMD_W-1:0] cmd,
                           logic [bbcf_pkg::BADDR_W-1:0] addr,
                           logic [bbcf_pkg::SLOT_W-1:0] sidx, logic dval, int phase,
                           logic drain);
        cache_cmd_t c;
        c.cmd = cmd;
        c.block_addr = addr;
        c.slot_idx = sidx;
        c.dirty_val = dval;
        c.phase = 2'(phase);
        c.drain = drain;
        pending_cmds.push_back(c);
    endtask

    initial begin
        int pick;
        logic [bbcf_pkg::BADDR_W-1:0] addr;

        for (int i = 0; i < bbcf_pkg::CACHE_SLOTS; i++) begin
            slot_block[i] = bbcf_pkg::BADDR_W'(i);
            slot_dirty[i] = 1'b0;
        end
        victim_slot = '0;

        // directed: hits on reset contents, extremes, dirty and clean misses, flushes
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'd0, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'd15, 4'hF, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'hFFFFFF, 4'hF, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_FLUSH, 24'hFFFFFF, 4'hF, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'hFFFFFF, 4'd15, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd1, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd0, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_FLUSH, 24'd0, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_FLUSH, 24'd0, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd1, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'h800000, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd2, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd2, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'd2, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(CMD_UNKNOWN, 24'hFFFFFF, 4'hF, 1'b1, 0, 1'b0);
        add_cmd(CMD_UNKNOWN, 24'd0, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'hFFFFFF, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'h800000, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_ACCESS, 24'h000001, 4'd0, 1'b0, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd0, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_MARK, 24'd0, 4'd3, 1'b1, 0, 1'b0);
        add_cmd(bbcf_pkg::CMD_FLUSH, 24'd0, 4'd0, 1'b0, 0, 1'b0);

        // working set larger than the cache so hits, misses and wraps all occur
        for (int i = 0; i < POOL_SIZE; i++)
            addr_pool[i] = (i < 8) ? bbcf_pkg::BADDR_W'(i) : bbcf_pkg::BADDR_W'($urandom);

        for (int p = 0; p < NUM_PHASES; p++)
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                pick = $urandom_range(99);
                if ($urandom_range(3) == 0)
                    addr = bbcf_pkg::BADDR_W'($urandom);
                else
                    addr = addr_pool[5'($urandom_range(POOL_SIZE - 1))];
                if (pick < 55)
                    add_cmd(bbcf_pkg::CMD_ACCESS, addr, bbcf_pkg::SLOT_W'($urandom),
                            1'($urandom), p, k == 0);
                else if (pick < 82)
                    add_cmd(bbcf_pkg::CMD_MARK, bbcf_pkg::BADDR_W'($urandom),
                            bbcf_pkg::SLOT_W'($urandom), $urandom_range(9) < 7, p, k == 0);
                else if (pick < 94)
                    add_cmd(bbcf_pkg::CMD_FLUSH, bbcf_pkg::BADDR_W'($urandom),
                            bbcf_pkg::SLOT_W'($urandom), 1'($urandom), p, k == 0);
                else
                    add_cmd(CMD_UNKNOWN, bbcf_pkg::BADDR_W'($urandom),
                            bbcf_pkg::SLOT_W'($urandom), 1'($urandom), p, k == 0);
            end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("** block_buffer_cache_fifo_top: PASSED **");
        else
            $display("** block_buffer_cache_fifo_top: FAILED **");
        $finish;
    end

endmodule

// ===== block_buffer_cache_fifo_top.f =====
rtl/bbcf_pkg.sv
rtl/bbcf_ram.sv
rtl/block_buffer_cache_fifo_top.sv
test/block_buffer_cache_fifo_top_tb.sv
